### hw/rtl/iltm_pkg.sv
`default_nettype none

package iltm_pkg;

  // event codes on the func field
  localparam logic [2:0] FUNC_TICK     = 3'd0;
  localparam logic [2:0] FUNC_RD_BEGIN = 3'd1;
  localparam logic [2:0] FUNC_RD_END   = 3'd2;
  localparam logic [2:0] FUNC_WR_BEGIN = 3'd3;
  localparam logic [2:0] FUNC_WR_END   = 3'd4;
  localparam logic [2:0] FUNC_UPDATE   = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_GRANT  = 2'd0;
  localparam logic [1:0] KIND_NOSLOT = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  // report item codes
  localparam logic [3:0] ITEM_RD_MBS  = 4'd0;
  localparam logic [3:0] ITEM_WR_MBS  = 4'd1;
  localparam logic [3:0] ITEM_RD_AVG  = 4'd2;
  localparam logic [3:0] ITEM_WR_AVG  = 4'd3;
  localparam logic [3:0] ITEM_RD_IOPS = 4'd4;
  localparam logic [3:0] ITEM_WR_IOPS = 4'd5;
  localparam logic [3:0] ITEM_QD_NOW  = 4'd6;
  localparam logic [3:0] ITEM_QD_PEAK = 4'd7;
  localparam logic [3:0] ITEM_RD_MIN  = 4'd8;
  localparam logic [3:0] ITEM_WR_MIN  = 4'd9;
  localparam logic [3:0] ITEM_RD_MAX  = 4'd10;
  localparam logic [3:0] ITEM_WR_MAX  = 4'd11;
  localparam logic [3:0] ITEM_LAST    = ITEM_WR_MAX;

  // update job sequence: two averages, then one job per report item
  localparam logic [3:0] JOB_FIRST_ITEM = 4'd2;
  localparam logic [3:0] JOB_LAST       = JOB_FIRST_ITEM + ITEM_LAST;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TPS     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_INT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HALVE   = 2'd2;

  // arithmetic constants
  localparam logic [63:0] LAT_SCALE   = 64'd256000;
  localparam logic [3:0]  RATE_SHIFT  = 4'd12;
  localparam logic [7:0]  PENDING_MAX = 8'hFF;

  // front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // multiply-divide unit
  localparam int unsigned DIV_STEPS = 128;
  localparam int unsigned DCNT_BITS = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    OP_TICK,
    OP_BEGIN,
    OP_END,
    OP_UPDATE,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        dir;      // 0 read, 1 write
    logic        slot_ok;  // slot index within range
    logic [7:0]  slot;
    logic [31:0] bytes;
    logic [63:0] tr;
    logic [63:0] tw;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [3:0]  sh;
  } md_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_END_CALC,
    ST_END_ACC,
    ST_END_HALVE,
    ST_UPD_CHECK,
    ST_UPD_GATE,
    ST_UPD_SETUP,
    ST_UPD_START,
    ST_UPD_WAIT,
    ST_UPD_EMIT
  } back_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

endpackage

`default_nettype wire

### hw/rtl/iltm_event_if.sv
`default_nettype none

interface iltm_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [7:0]  slot;
  logic [31:0] byte_count;
  logic [63:0] total_read;
  logic [63:0] total_written;

  modport source (output valid, func, slot, byte_count, total_read, total_written,
                  input ready);
  modport sink   (input valid, func, slot, byte_count, total_read, total_written,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/iltm_result_if.sv
`default_nettype none

interface iltm_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  granted_slot;
  logic [3:0]  item_code;
  logic [63:0] value;
  logic        last;

  modport source (output valid, kind, granted_slot, item_code, value, last,
                  input ready);
  modport sink   (input valid, kind, granted_slot, item_code, value, last,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/iltm_cfg_if.sv
`default_nettype none

interface iltm_cfg_if;
  logic        valid;
  logic        ready;
  logic [iltm_pkg::CFG_INDEX_BITS-1:0] index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### hw/rtl/iltm_ram.sv
`default_nettype none

module iltm_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/iltm_front.sv
`default_nettype none

module iltm_front #(
  parameter int unsigned SLOT_COUNT = 8
) (
  iltm_event_if.sink         events,
  input  wire logic          full,
  output logic               push,
  output iltm_pkg::entry_t   entry
);

  // one beat per cycle while the queue has room
  assign events.ready = !full;
  assign push         = events.valid && !full;

  // decode func into operation and direction, range-check the slot
  always_comb begin
    entry.op      = iltm_pkg::OP_NONE;
    entry.dir     = 1'b0;
    entry.slot_ok = ({24'd0, events.slot} < 32'(SLOT_COUNT));
    entry.slot    = events.slot;
    entry.bytes   = events.byte_count;
    entry.tr      = events.total_read;
    entry.tw      = events.total_written;
    case (events.func)
      iltm_pkg::FUNC_TICK:     entry.op = iltm_pkg::OP_TICK;
      iltm_pkg::FUNC_RD_BEGIN: entry.op = iltm_pkg::OP_BEGIN;
      iltm_pkg::FUNC_RD_END:   entry.op = iltm_pkg::OP_END;
      iltm_pkg::FUNC_WR_BEGIN: begin
        entry.op  = iltm_pkg::OP_BEGIN;
        entry.dir = 1'b1;
      end
      iltm_pkg::FUNC_WR_END: begin
        entry.op  = iltm_pkg::OP_END;
        entry.dir = 1'b1;
      end
      iltm_pkg::FUNC_UPDATE:   entry.op = iltm_pkg::OP_UPDATE;
      default:                 entry.op = iltm_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/iltm_queue.sv
`default_nettype none

module iltm_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire iltm_pkg::entry_t  wr_entry,
  input  wire logic              pop,
  output logic                   full,
  output logic                   nonempty,
  output iltm_pkg::entry_t       head
);

  localparam int unsigned PB = iltm_pkg::QPTR_BITS;

  iltm_pkg::entry_t   mem [iltm_pkg::QUEUE_DEPTH];
  logic [PB-1:0]      wptr;
  logic [PB-1:0]      rptr;
  logic [PB:0]        count;

  assign full     = (count == (PB+1)'(iltm_pkg::QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign head     = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_entry;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/iltm_muldiv.sv
`default_nettype none

// floor(a * b / c) >> sh, saturated to 64 bits, all ones for c == 0.
// Four 32x32 partial products, then one quotient bit per cycle.
module iltm_muldiv (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire iltm_pkg::md_req_t req,
  output logic                   done,
  output logic [63:0]            result
);

  localparam int unsigned DB = iltm_pkg::DCNT_BITS;

  iltm_pkg::md_state_t state, state_next;

  logic [63:0]   a, b, c;
  logic [3:0]    sh;
  logic [63:0]   pp;
  logic [1:0]    pidx;
  logic [2:0]    step;
  logic [127:0]  acc;
  logic [127:0]  dq;
  logic [63:0]   rem;
  logic [DB-1:0] dcnt;

  logic [31:0]   a_part, b_part;
  logic [127:0]  pp_shifted;
  logic [64:0]   trial;
  logic          ge;
  logic [127:0]  q_shifted;

  assign a_part = step[0] ? a[63:32] : a[31:0];
  assign b_part = step[1] ? b[63:32] : b[31:0];

  always_comb begin
    case (pidx)
      2'd0:    pp_shifted = {64'd0, pp};
      2'd3:    pp_shifted = {pp, 64'd0};
      default: pp_shifted = {32'd0, pp, 32'd0};
    endcase
  end

  assign trial     = {rem, dq[127]};
  assign ge        = (trial >= {1'b0, c});
  assign q_shifted = dq >> sh;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iltm_pkg::MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and outputs
  always_comb begin
    state_next = state;
    done       = 1'b0;
    result     = '1;
    case (state)
      iltm_pkg::MD_IDLE: begin
        if (req.start) begin
          state_next = iltm_pkg::MD_MUL;
        end
      end
      iltm_pkg::MD_MUL: begin
        if (step == 3'd4) begin
          state_next = iltm_pkg::MD_DIV;
        end
      end
      iltm_pkg::MD_DIV: begin
        if (dcnt == DB'(iltm_pkg::DIV_STEPS - 1)) begin
          state_next = iltm_pkg::MD_DONE;
        end
      end
      iltm_pkg::MD_DONE: begin
        done       = 1'b1;
        if (c != '0 && q_shifted[127:64] == '0) begin
          result = q_shifted[63:0];
        end
        state_next = iltm_pkg::MD_IDLE;
      end
      default: state_next = iltm_pkg::MD_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      iltm_pkg::MD_IDLE: begin
        if (req.start) begin
          a    <= req.a;
          b    <= req.b;
          c    <= req.c;
          sh   <= req.sh;
          acc  <= '0;
          step <= '0;
        end
      end
      iltm_pkg::MD_MUL: begin
        // partial product registered, added in the next cycle
        if (step != 3'd4) begin
          pp   <= 64'(a_part) * 64'(b_part);
          pidx <= step[1:0];
        end
        if (step != 3'd0) begin
          acc <= acc + pp_shifted;
        end
        if (step == 3'd4) begin
          dq   <= acc + pp_shifted;
          rem  <= '0;
          dcnt <= '0;
        end
        step <= step + 3'd1;
      end
      iltm_pkg::MD_DIV: begin
        rem  <= ge ? 64'(trial - {1'b0, c}) : trial[63:0];
        dq   <= {dq[126:0], ge};
        dcnt <= dcnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (state == iltm_pkg::MD_IDLE))
    else $error("multiply-divide started while busy");

endmodule

`default_nettype wire

### hw/rtl/iltm_back.sv
`default_nettype none

module iltm_back #(
  parameter int unsigned SLOT_COUNT = 8,
  parameter int unsigned TIME_BITS  = 48,
  localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              nonempty,
  input  wire iltm_pkg::entry_t  head,
  output logic                   pop,
  iltm_cfg_if.sink               cfg,
  iltm_result_if.source          results
);

  localparam int unsigned TB = TIME_BITS;

  iltm_pkg::back_state_t state, state_next;

  // configuration
  logic [31:0] tps;
  logic [31:0] min_int;
  logic [19:0] halve_lim;

  // statistics state
  logic [TB-1:0]   now_time;
  logic [SLOT_COUNT-1:0] busy;
  logic [7:0]      pending;
  logic [7:0]      qd_now;
  logic [7:0]      qd_peak;
  logic [63:0]     op_cnt   [2];
  logic [63:0]     byte_tot [2];
  logic [63:0]     lat_sum  [2];
  logic [20:0]     lat_cnt  [2];
  logic [31:0]     lat_min  [2];
  logic [31:0]     lat_max  [2];
  logic [39:0]     avg      [2];
  logic [63:0]     snap_rd, snap_wr, snap_ro, snap_wo;
  logic [TB-1:0]   snap_t;

  // work registers
  logic            cur_dir;
  logic [SW-1:0]   cur_slot;
  logic [31:0]     cur_bytes;
  logic [TB-1:0]   el;
  logic [63:0]     upd_tr, upd_tw;
  logic [TB-1:0]   dt;
  logic [63:0]     d_rd, d_wr, d_ro, d_wo;
  logic [3:0]      jidx;
  logic [63:0]     val;
  logic [63:0]     md_a, md_b, md_c;
  logic [3:0]      md_sh;

  // operands of the next update job
  logic [63:0]     val_next;
  logic [63:0]     md_a_next, md_b_next, md_c_next;
  logic [3:0]      md_sh_next;

  // output register
  logic            o_valid;
  logic [1:0]      o_kind;
  logic [2:0]      o_gs;
  logic [3:0]      o_item;
  logic [63:0]     o_value;
  logic            o_last;

  iltm_pkg::md_req_t md_req;
  logic              md_done;
  logic [63:0]       md_result;
  logic              md_start;

  logic [TB-1:0] t0_rdata;
  logic          out_free;
  logic          free_found;
  logic [SW-1:0] free_idx;
  logic          end_ok;
  logic [7:0]    pend_inc;
  logic          ram_we;
  logic [3:0]    item;
  logic [63:0]   el64;
  logic [31:0]   el32;
  logic [64:0]   sum_ext;
  logic [52:0]   cnt_f;
  logic          job_dir;

  assign out_free = !o_valid || results.ready;
  assign end_ok   = head.slot_ok && busy[head.slot[SW-1:0]];
  assign pend_inc = (pending == iltm_pkg::PENDING_MAX) ? pending : pending + 8'd1;
  assign item     = jidx - iltm_pkg::JOB_FIRST_ITEM;
  assign el64     = 64'(el);
  assign el32     = (el64[63:32] != '0) ? 32'hFFFF_FFFF : el64[31:0];
  assign sum_ext  = {1'b0, lat_sum[cur_dir]} + 65'(el);
  assign job_dir  = jidx[0];
  assign cnt_f    = 53'(job_dir ? lat_cnt[1] : lat_cnt[0]) * 53'(tps);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
      if (!busy[s]) begin
        free_found = 1'b1;
        free_idx   = SW'(s);
      end
    end
  end

  assign ram_we = (state == iltm_pkg::ST_IDLE) && nonempty &&
                  (head.op == iltm_pkg::OP_BEGIN) && out_free && free_found;

  // start times of open transfers
  iltm_ram #(.WIDTH(TB), .DEPTH(SLOT_COUNT)) u_start_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (now_time),
    .raddr (head.slot[SW-1:0]),
    .rdata (t0_rdata)
  );

  assign md_req.start = md_start;
  assign md_req.a     = md_a;
  assign md_req.b     = md_b;
  assign md_req.c     = md_c;
  assign md_req.sh    = md_sh;

  iltm_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .req    (md_req),
    .done   (md_done),
    .result (md_result)
  );

  // configuration writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tps       <= 32'd1000000;
      min_int   <= 32'd500000;
      halve_lim <= 20'd1000000;
    end else if (cfg.valid) begin
      case (cfg.index)
        iltm_pkg::CFG_TPS:     tps       <= cfg.data;
        iltm_pkg::CFG_MIN_INT: min_int   <= cfg.data;
        iltm_pkg::CFG_HALVE:   halve_lim <= cfg.data[19:0];
        default: begin
        end
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iltm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, queue pop and divider start
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    md_start   = 1'b0;
    case (state)
      iltm_pkg::ST_IDLE: begin
        if (nonempty) begin
          case (head.op)
            iltm_pkg::OP_BEGIN: pop = out_free;
            iltm_pkg::OP_END: begin
              pop = 1'b1;
              if (end_ok) begin
                state_next = iltm_pkg::ST_END_CALC;
              end
            end
            iltm_pkg::OP_UPDATE: begin
              pop        = 1'b1;
              state_next = iltm_pkg::ST_UPD_CHECK;
            end
            default: pop = 1'b1;
          endcase
        end
      end
      iltm_pkg::ST_END_CALC:  state_next = iltm_pkg::ST_END_ACC;
      iltm_pkg::ST_END_ACC:   state_next = iltm_pkg::ST_END_HALVE;
      iltm_pkg::ST_END_HALVE: state_next = iltm_pkg::ST_IDLE;
      iltm_pkg::ST_UPD_CHECK: state_next = iltm_pkg::ST_UPD_GATE;
      iltm_pkg::ST_UPD_GATE: begin
        if (64'(dt) < 64'(min_int)) begin
          state_next = iltm_pkg::ST_IDLE;
        end else begin
          state_next = iltm_pkg::ST_UPD_SETUP;
        end
      end
      iltm_pkg::ST_UPD_SETUP: begin
        if (jidx < iltm_pkg::JOB_FIRST_ITEM) begin
          if ((job_dir ? lat_cnt[1] : lat_cnt[0]) != '0) begin
            state_next = iltm_pkg::ST_UPD_START;
          end
        end else begin
          case (item)
            iltm_pkg::ITEM_RD_MBS, iltm_pkg::ITEM_WR_MBS,
            iltm_pkg::ITEM_RD_IOPS, iltm_pkg::ITEM_WR_IOPS: begin
              if (dt == '0) begin
                state_next = iltm_pkg::ST_UPD_EMIT;
              end else begin
                state_next = iltm_pkg::ST_UPD_START;
              end
            end
            iltm_pkg::ITEM_RD_AVG, iltm_pkg::ITEM_WR_AVG,
            iltm_pkg::ITEM_QD_NOW, iltm_pkg::ITEM_QD_PEAK:
              state_next = iltm_pkg::ST_UPD_EMIT;
            default: state_next = iltm_pkg::ST_UPD_START;
          endcase
        end
      end
      iltm_pkg::ST_UPD_START: begin
        md_start   = 1'b1;
        state_next = iltm_pkg::ST_UPD_WAIT;
      end
      iltm_pkg::ST_UPD_WAIT: begin
        if (md_done) begin
          if (jidx < iltm_pkg::JOB_FIRST_ITEM) begin
            state_next = iltm_pkg::ST_UPD_SETUP;
          end else begin
            state_next = iltm_pkg::ST_UPD_EMIT;
          end
        end
      end
      iltm_pkg::ST_UPD_EMIT: begin
        if (out_free) begin
          if (item == iltm_pkg::ITEM_LAST) begin
            state_next = iltm_pkg::ST_IDLE;
          end else begin
            state_next = iltm_pkg::ST_UPD_SETUP;
          end
        end
      end
      default: state_next = iltm_pkg::ST_IDLE;
    endcase
  end

  // statistics state
  always_ff @(posedge clk) begin
    if (rst) begin
      now_time   <= '0;
      busy       <= '0;
      pending    <= '0;
      qd_now     <= '0;
      qd_peak    <= '0;
      op_cnt[0]  <= '0;
      op_cnt[1]  <= '0;
      byte_tot[0] <= '0;
      byte_tot[1] <= '0;
      lat_sum[0] <= '0;
      lat_sum[1] <= '0;
      lat_cnt[0] <= '0;
      lat_cnt[1] <= '0;
      lat_min[0] <= '1;
      lat_min[1] <= '1;
      lat_max[0] <= '0;
      lat_max[1] <= '0;
      avg[0]     <= '0;
      avg[1]     <= '0;
      snap_rd    <= '0;
      snap_wr    <= '0;
      snap_ro    <= '0;
      snap_wo    <= '0;
      snap_t     <= '0;
    end else begin
      case (state)
        iltm_pkg::ST_IDLE: begin
          if (nonempty && head.op == iltm_pkg::OP_TICK) begin
            now_time <= now_time + 1'b1;
          end
          if (nonempty && head.op == iltm_pkg::OP_BEGIN && out_free) begin
            pending <= pend_inc;
            if (head.dir) begin
              qd_now <= pend_inc;
              if (pend_inc > qd_peak) begin
                qd_peak <= pend_inc;
              end
            end
            if (free_found) begin
              busy[free_idx] <= 1'b1;
            end
          end
        end
        iltm_pkg::ST_END_CALC: begin
          busy[cur_slot] <= 1'b0;
          if (pending != '0) begin
            pending <= pending - 8'd1;
          end
        end
        iltm_pkg::ST_END_ACC: begin
          op_cnt[cur_dir]   <= op_cnt[cur_dir] + 64'd1;
          byte_tot[cur_dir] <= byte_tot[cur_dir] + 64'(cur_bytes);
          lat_sum[cur_dir]  <= sum_ext[64] ? '1 : sum_ext[63:0];
          lat_cnt[cur_dir]  <= lat_cnt[cur_dir] + 21'd1;
          if (el32 > lat_max[cur_dir]) begin
            lat_max[cur_dir] <= el32;
          end
          if (el32 < lat_min[cur_dir]) begin
            lat_min[cur_dir] <= el32;
          end
        end
        iltm_pkg::ST_END_HALVE: begin
          if (lat_cnt[cur_dir] > {1'b0, halve_lim}) begin
            lat_sum[cur_dir] <= lat_sum[cur_dir] >> 1;
            lat_cnt[cur_dir] <= lat_cnt[cur_dir] >> 1;
          end
        end
        iltm_pkg::ST_UPD_GATE: begin
          if (64'(dt) >= 64'(min_int)) begin
            snap_rd <= upd_tr;
            snap_wr <= upd_tw;
            snap_ro <= op_cnt[0];
            snap_wo <= op_cnt[1];
            snap_t  <= now_time;
          end
        end
        iltm_pkg::ST_UPD_WAIT: begin
          if (md_done && jidx < iltm_pkg::JOB_FIRST_ITEM) begin
            if (job_dir) begin
              avg[1] <= (md_result[63:40] != '0) ? '1 : md_result[39:0];
            end else begin
              avg[0] <= (md_result[63:40] != '0) ? '1 : md_result[39:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // operand selection for the current job
  always_comb begin
    md_sh_next = '0;
    md_b_next  = iltm_pkg::LAT_SCALE;
    md_c_next  = 64'(tps);
    md_a_next  = '0;
    val_next   = '0;
    if (jidx < iltm_pkg::JOB_FIRST_ITEM) begin
      md_a_next = job_dir ? lat_sum[1] : lat_sum[0];
      md_c_next = 64'(cnt_f);
    end else begin
      case (item)
        iltm_pkg::ITEM_RD_MBS: begin
          md_a_next  = d_rd;
          md_b_next  = 64'(tps);
          md_c_next  = 64'(dt);
          md_sh_next = iltm_pkg::RATE_SHIFT;
        end
        iltm_pkg::ITEM_WR_MBS: begin
          md_a_next  = d_wr;
          md_b_next  = 64'(tps);
          md_c_next  = 64'(dt);
          md_sh_next = iltm_pkg::RATE_SHIFT;
        end
        iltm_pkg::ITEM_RD_AVG:  val_next = 64'(avg[0]);
        iltm_pkg::ITEM_WR_AVG:  val_next = 64'(avg[1]);
        iltm_pkg::ITEM_RD_IOPS: begin
          md_a_next = d_ro;
          md_b_next = 64'(tps) << 8;
          md_c_next = 64'(dt);
        end
        iltm_pkg::ITEM_WR_IOPS: begin
          md_a_next = d_wo;
          md_b_next = 64'(tps) << 8;
          md_c_next = 64'(dt);
        end
        iltm_pkg::ITEM_QD_NOW:  val_next  = 64'(qd_now);
        iltm_pkg::ITEM_QD_PEAK: val_next  = 64'(qd_peak);
        iltm_pkg::ITEM_RD_MIN:  md_a_next = 64'(lat_min[0]);
        iltm_pkg::ITEM_WR_MIN:  md_a_next = 64'(lat_min[1]);
        iltm_pkg::ITEM_RD_MAX:  md_a_next = 64'(lat_max[0]);
        default:                md_a_next = 64'(lat_max[1]);
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    case (state)
      iltm_pkg::ST_IDLE: begin
        cur_dir   <= head.dir;
        cur_slot  <= head.slot[SW-1:0];
        cur_bytes <= head.bytes;
        upd_tr    <= head.tr;
        upd_tw    <= head.tw;
        jidx      <= '0;
      end
      iltm_pkg::ST_END_CALC: el <= now_time - t0_rdata;
      iltm_pkg::ST_UPD_CHECK: begin
        dt   <= now_time - snap_t;
        d_rd <= (upd_tr > snap_rd) ? upd_tr - snap_rd : '0;
        d_wr <= (upd_tw > snap_wr) ? upd_tw - snap_wr : '0;
        d_ro <= (op_cnt[0] > snap_ro) ? op_cnt[0] - snap_ro : '0;
        d_wo <= (op_cnt[1] > snap_wo) ? op_cnt[1] - snap_wo : '0;
      end
      iltm_pkg::ST_UPD_SETUP: begin
        md_sh <= md_sh_next;
        md_b  <= md_b_next;
        md_c  <= md_c_next;
        md_a  <= md_a_next;
        val   <= val_next;
        // no samples in this direction: skip its average
        if (jidx < iltm_pkg::JOB_FIRST_ITEM &&
            (job_dir ? lat_cnt[1] : lat_cnt[0]) == '0) begin
          jidx <= jidx + 4'd1;
        end
      end
      iltm_pkg::ST_UPD_WAIT: begin
        if (md_done) begin
          val <= md_result;
          if (jidx < iltm_pkg::JOB_FIRST_ITEM) begin
            jidx <= jidx + 4'd1;
          end
        end
      end
      iltm_pkg::ST_UPD_EMIT: begin
        if (out_free) begin
          jidx <= jidx + 4'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register: grant or no-slot beats from begins, report beats from updates
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (state == iltm_pkg::ST_IDLE && nonempty &&
                 head.op == iltm_pkg::OP_BEGIN && out_free) begin
      o_valid <= 1'b1;
    end else if (state == iltm_pkg::ST_UPD_EMIT && out_free) begin
      o_valid <= 1'b1;
    end else if (results.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == iltm_pkg::ST_IDLE && nonempty &&
        head.op == iltm_pkg::OP_BEGIN && out_free) begin
      o_kind  <= free_found ? iltm_pkg::KIND_GRANT : iltm_pkg::KIND_NOSLOT;
      o_gs    <= free_found ? 3'(free_idx) : 3'd0;
      o_item  <= '0;
      o_value <= '0;
      o_last  <= 1'b0;
    end else if (state == iltm_pkg::ST_UPD_EMIT && out_free) begin
      o_kind  <= iltm_pkg::KIND_REPORT;
      o_gs    <= '0;
      o_item  <= item;
      o_value <= val;
      o_last  <= (item == iltm_pkg::ITEM_LAST);
    end
  end

  assign results.valid        = o_valid;
  assign results.kind         = o_kind;
  assign results.granted_slot = o_gs;
  assign results.item_code    = o_item;
  assign results.value        = o_value;
  assign results.last         = o_last;

  a_end_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == iltm_pkg::ST_END_CALC) |-> ($past(state) == iltm_pkg::ST_IDLE))
    else $error("latency computed without a start time read");

  a_last_item: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_last) |-> (o_item == iltm_pkg::ITEM_LAST && o_kind == iltm_pkg::KIND_REPORT))
    else $error("last flag on a beat other than the final report item");

  a_job_range: assert property (@(posedge clk) disable iff (rst)
    (state == iltm_pkg::ST_UPD_SETUP) |-> (jidx <= iltm_pkg::JOB_LAST))
    else $error("update job index past the final item");

endmodule

`default_nettype wire

### hw/rtl/io_latency_throughput_monitor.sv
// IO latency and throughput monitor. Event beats enter through a four-entry queue, so
// the block keeps accepting while a result waits on the output. Ticks, begins and
// ends that are ignored are handled in the idle state alone; a valid end passes
// through start-time RAM read, latency, accumulation and halving check in turn; an
// update that comes too early stops after its interval check. An accepted update
// runs up to ten operations through one shared multiply-divide unit (four partial
// products, then a bit-serial division) and emits twelve report beats. A begin
// answers with one beat, an accepted update with twelve (last set on the final one);
// ticks and ends answer nothing. The configuration port is always ready and must
// only be written while the block is idle.
`default_nettype none

module io_latency_throughput_monitor #(
  parameter int unsigned SLOT_COUNT = 8,
  parameter int unsigned TIME_BITS  = 48
) (
  input  wire logic      clk,
  input  wire logic      rst,
  iltm_event_if.sink     events,
  iltm_result_if.source  results,
  iltm_cfg_if.sink       cfg
);

  iltm_pkg::entry_t wr_entry;
  iltm_pkg::entry_t head;
  logic             push;
  logic             pop;
  logic             full;
  logic             nonempty;

  iltm_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
    .events (events),
    .full   (full),
    .push   (push),
    .entry  (wr_entry)
  );

  iltm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .full     (full),
    .nonempty (nonempty),
    .head     (head)
  );

  iltm_back #(.SLOT_COUNT(SLOT_COUNT), .TIME_BITS(TIME_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .cfg      (cfg),
    .results  (results)
  );

endmodule

`default_nettype wire

### sim/iltm_tb_ifs.sv
`timescale 1ns / 100ps
`default_nettype none

// Interfaces used by the testbench are the ones from the RTL; this file only
// holds shared testbench types.
package iltm_tb_pkg;
  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  slot;
    logic [31:0] byte_count;
    logic [63:0] total_read;
    logic [63:0] total_written;
  } ev_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  granted_slot;
    logic [3:0]  item_code;
    logic [63:0] value;
    logic        last;
  } res_beat_t;
endpackage

`default_nettype wire

### sim/io_latency_throughput_monitor_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module io_latency_throughput_monitor_tb;

  localparam int unsigned NSLOT = 8;
  localparam logic [47:0] TMASK = '1;
  localparam int unsigned IDLE_WAIT = 3000;
  localparam int unsigned DOG_LIMIT = 200000;

  logic clk;
  logic rst;

  iltm_event_if  ev_if ();
  iltm_result_if res_if ();
  iltm_cfg_if    cfg_if ();

  io_latency_throughput_monitor u_dut (
    .clk     (clk),
    .rst     (rst),
    .events  (ev_if.sink),
    .results (res_if.source),
    .cfg     (cfg_if.sink)
  );

  // predictor state
  logic [31:0] tps, min_int;
  logic [19:0] halve_lim;
  logic [47:0] now_t;
  logic        busy [NSLOT];
  logic [47:0] start_t [NSLOT];
  logic [7:0]  pend, qd_now, qd_peak;
  logic [63:0] ops [2], bytes_tot [2], lat_sum [2];
  logic [20:0] lat_cnt [2];
  logic [31:0] lat_min [2], lat_max [2];
  logic [39:0] lat_avg [2];
  logic [63:0] snap [5];

  iltm_tb_pkg::ev_beat_t  pending_beats [$];
  iltm_tb_pkg::res_beat_t expected_res [$];
  int        errors;
  int        gap_left;
  int        hold_left;
  int        quiet;
  bit        ev_taken;
  bit        sender_pause;
  bit        recv_hold_req;

  // floor(a*b/c) >> sh with 64-bit saturation; all ones for c == 0
  function automatic logic [63:0] muldiv(logic [63:0] a, logic [63:0] b,
                                         logic [63:0] c, int sh);
    logic [127:0] q;
    if (c == 0) return '1;
    q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
    q = q >> sh;
    return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
  endfunction

  function automatic iltm_tb_pkg::res_beat_t mk(logic [1:0] k, logic [2:0] g,
                                                logic [3:0] it, logic [63:0] v, logic l);
    iltm_tb_pkg::res_beat_t r;
    r.kind = k; r.granted_slot = g; r.item_code = it; r.value = v; r.last = l;
    return r;
  endfunction

  task automatic predictor_reset();
    tps = 32'd1000000; min_int = 32'd500000; halve_lim = 20'd1000000;
    now_t = '0; pend = '0; qd_now = '0; qd_peak = '0;
    for (int i = 0; i < NSLOT; i++) begin
      busy[i] = 1'b0; start_t[i] = '0;
    end
    for (int d = 0; d < 2; d++) begin
      ops[d] = '0; bytes_tot[d] = '0; lat_sum[d] = '0; lat_cnt[d] = '0;
      lat_min[d] = '1; lat_max[d] = '0; lat_avg[d] = '0;
    end
    for (int i = 0; i < 5; i++) snap[i] = '0;
  endtask

  // apply one accepted event beat and queue what the block should answer
  task automatic predict_event(iltm_tb_pkg::ev_beat_t e);
    int d;
    int s;
    logic [47:0] el;
    logic [31:0] el32;
    logic [47:0] dt;
    logic [63:0] dr, dw, dor, dow, a;
    logic [63:0] v [12];
    bit found;
    case (e.func)
      iltm_pkg::FUNC_TICK: now_t = now_t + 48'd1;
      iltm_pkg::FUNC_RD_BEGIN, iltm_pkg::FUNC_WR_BEGIN: begin
        if (pend != iltm_pkg::PENDING_MAX) pend = pend + 8'd1;
        if (e.func == iltm_pkg::FUNC_WR_BEGIN) begin
          qd_now = pend;
          if (pend > qd_peak) qd_peak = pend;
        end
        found = 0;
        for (s = 0; s < NSLOT; s++) begin
          if (!found && !busy[s]) begin
            found = 1; busy[s] = 1'b1; start_t[s] = now_t;
            expected_res.push_back(mk(iltm_pkg::KIND_GRANT, s[2:0], '0, '0, 1'b0));
          end
        end
        if (!found) expected_res.push_back(mk(iltm_pkg::KIND_NOSLOT, '0, '0, '0, 1'b0));
      end
      iltm_pkg::FUNC_RD_END, iltm_pkg::FUNC_WR_END: begin
        d = (e.func == iltm_pkg::FUNC_WR_END) ? 1 : 0;
        if (e.slot < NSLOT && busy[e.slot]) begin
          el = (now_t - start_t[e.slot]) & TMASK;
          busy[e.slot] = 1'b0;
          if (pend != 0) pend = pend - 8'd1;
          ops[d] = ops[d] + 64'd1;
          bytes_tot[d] = bytes_tot[d] + 64'(e.byte_count);
          lat_sum[d] = (lat_sum[d] > ~64'(el)) ? '1 : lat_sum[d] + 64'(el);
          lat_cnt[d] = lat_cnt[d] + 21'd1;
          el32 = (el > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : el[31:0];
          if (el32 > lat_max[d]) lat_max[d] = el32;
          if (el32 < lat_min[d]) lat_min[d] = el32;
          if (lat_cnt[d] > 21'(halve_lim)) begin
            lat_sum[d] = lat_sum[d] >> 1;
            lat_cnt[d] = lat_cnt[d] >> 1;
          end
        end
      end
      iltm_pkg::FUNC_UPDATE: begin
        dt = (now_t - snap[4][47:0]) & TMASK;
        if (dt >= 48'(min_int)) begin
          dr  = (e.total_read > snap[0]) ? e.total_read - snap[0] : '0;
          dw  = (e.total_written > snap[1]) ? e.total_written - snap[1] : '0;
          dor = (ops[0] > snap[2]) ? ops[0] - snap[2] : '0;
          dow = (ops[1] > snap[3]) ? ops[1] - snap[3] : '0;
          for (int k = 0; k < 2; k++) begin
            if (lat_cnt[k] != 0) begin
              a = muldiv(lat_sum[k], 64'd256000, 64'(lat_cnt[k]) * 64'(tps), 0);
              lat_avg[k] = (a > 64'hFF_FFFF_FFFF) ? '1 : a[39:0];
            end
          end
          v[0]  = (dt != 0) ? muldiv(dr, 64'(tps), 64'(dt), 12) : '0;
          v[1]  = (dt != 0) ? muldiv(dw, 64'(tps), 64'(dt), 12) : '0;
          v[2]  = 64'(lat_avg[0]);
          v[3]  = 64'(lat_avg[1]);
          v[4]  = (dt != 0) ? muldiv(dor, 64'(tps) << 8, 64'(dt), 0) : '0;
          v[5]  = (dt != 0) ? muldiv(dow, 64'(tps) << 8, 64'(dt), 0) : '0;
          v[6]  = 64'(qd_now);
          v[7]  = 64'(qd_peak);
          v[8]  = muldiv(64'(lat_min[0]), 64'd256000, 64'(tps), 0);
          v[9]  = muldiv(64'(lat_min[1]), 64'd256000, 64'(tps), 0);
          v[10] = muldiv(64'(lat_max[0]), 64'd256000, 64'(tps), 0);
          v[11] = muldiv(64'(lat_max[1]), 64'd256000, 64'(tps), 0);
          snap[0] = e.total_read; snap[1] = e.total_written;
          snap[2] = ops[0]; snap[3] = ops[1]; snap[4] = {16'd0, now_t};
          for (int k = 0; k < 12; k++)
            expected_res.push_back(mk(iltm_pkg::KIND_REPORT, '0, k[3:0], v[k], k == 11));
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // event driver: a beat stays on the bus until the monitor saw it taken
  always @(negedge clk) begin
    if (rst) begin
      ev_if.valid <= 1'b0;
    end else if (ev_if.valid && !ev_taken) begin
      // hold the current beat
    end else if (sender_pause || pending_beats.size() == 0) begin
      ev_if.valid <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      ev_if.valid <= 1'b0;
    end else begin
      ev_if.valid         <= 1'b1;
      ev_if.func          <= pending_beats[0].func;
      ev_if.slot          <= pending_beats[0].slot;
      ev_if.byte_count    <= pending_beats[0].byte_count;
      ev_if.total_read    <= pending_beats[0].total_read;
      ev_if.total_written <= pending_beats[0].total_written;
      gap_left <= pick_gap();
    end
  end

  // result ready with random stalls and a requested long hold-off
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
      hold_left <= 0;
    end else if (recv_hold_req && hold_left == 0) begin
      hold_left <= 4000;
      res_if.ready <= 1'b0;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      if (hold_left == 1) hold_left <= 0;
      res_if.ready <= (pick_gap() == 0) || ($urandom_range(0, 1) == 1);
    end
  end

  // monitor: predict on event acceptance, check on result acceptance
  always @(posedge clk) begin
    iltm_tb_pkg::res_beat_t w;
    if (rst) begin
      quiet <= 0;
      ev_taken <= 1'b0;
    end else begin
      ev_taken <= ev_if.valid && ev_if.ready;
      if (ev_if.valid && ev_if.ready) predict_event(pending_beats.pop_front());
      if (res_if.valid && res_if.ready) begin
        if (expected_res.size() == 0) begin
          report_mismatch("unexpected beat kind", 64'(res_if.kind), '0);
        end else begin
          w = expected_res.pop_front();
          if (res_if.kind != w.kind)
            report_mismatch("kind", 64'(res_if.kind), 64'(w.kind));
          if (res_if.granted_slot != w.granted_slot)
            report_mismatch("granted_slot", 64'(res_if.granted_slot), 64'(w.granted_slot));
          if (res_if.item_code != w.item_code)
            report_mismatch("item_code", 64'(res_if.item_code), 64'(w.item_code));
          if (res_if.value != w.value) report_mismatch("value", res_if.value, w.value);
          if (res_if.last != w.last)
            report_mismatch("last", 64'(res_if.last), 64'(w.last));
        end
      end
      if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready) ||
          hold_left > 0)
        quiet <= 0;
      else
        quiet <= quiet + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (quiet >= DOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic iltm_tb_pkg::ev_beat_t mkev(logic [2:0] f, logic [7:0] s,
                                                 logic [31:0] b, logic [63:0] tr,
                                                 logic [63:0] tw);
    iltm_tb_pkg::ev_beat_t e;
    e.func = f; e.slot = s; e.byte_count = b; e.total_read = tr; e.total_written = tw;
    return e;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic push(iltm_tb_pkg::ev_beat_t e);
    pending_beats.push_back(e);
  endtask

  task automatic ticks(int n);
    for (int i = 0; i < n; i++)
      push(mkev(iltm_pkg::FUNC_TICK, 8'($urandom()), $urandom(), rand64(), rand64()));
  endtask

  // wait until the block has drained everything
  task automatic drain();
    while (pending_beats.size() != 0 || ev_if.valid || expected_res.size() != 0)
      @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [iltm_pkg::CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      iltm_pkg::CFG_TPS:     tps = val;
      iltm_pkg::CFG_MIN_INT: min_int = val;
      iltm_pkg::CFG_HALVE:   halve_lim = val[19:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // one random phase: mostly begin/end traffic with ticks, an update now and then
  task automatic random_phase(int n, int upd_pct);
    logic [2:0] f;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) f = iltm_pkg::FUNC_TICK;
      else if (r < 45) f = iltm_pkg::FUNC_RD_BEGIN;
      else if (r < 60) f = iltm_pkg::FUNC_WR_BEGIN;
      else if (r < 73) f = iltm_pkg::FUNC_RD_END;
      else if (r < 86) f = iltm_pkg::FUNC_WR_END;
      else if (r < 86 + upd_pct) f = iltm_pkg::FUNC_UPDATE;
      else f = 3'($urandom_range(6, 7));
      push(mkev(f, ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 7)),
                $urandom(), rand64(), rand64()));
    end
  endtask

  initial begin
    errors = 0; gap_left = 0; sender_pause = 0; recv_hold_req = 0;
    ev_if.valid = 0; ev_if.func = '0; ev_if.slot = '0; ev_if.byte_count = '0;
    ev_if.total_read = '0; ev_if.total_written = '0;
    res_if.ready = 0;
    cfg_if.valid = 0; cfg_if.index = iltm_pkg::CFG_TPS; cfg_if.data = '0;
    predictor_reset();
    rst = 1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // small settings so updates are accepted quickly
    write_reg(iltm_pkg::CFG_TPS, 32'd1000);
    write_reg(iltm_pkg::CFG_MIN_INT, 32'd1);
    write_reg(iltm_pkg::CFG_HALVE, 32'd2);

    // directed: update with no time passed, begins past the slot count, bad ends,
    // falling totals, unused codes
    push(mkev(iltm_pkg::FUNC_UPDATE, '0, '0, '1, '1));
    ticks(3);
    push(mkev(iltm_pkg::FUNC_UPDATE, '0, '0, '1, '1));
    for (int i = 0; i < 9; i++)
      push(mkev(i[0] ? iltm_pkg::FUNC_WR_BEGIN : iltm_pkg::FUNC_RD_BEGIN, '0, '0, '0, '0));
    ticks(2);
    push(mkev(iltm_pkg::FUNC_RD_END, 8'hFF, '1, '0, '0));
    push(mkev(iltm_pkg::FUNC_RD_END, 8'd8, '1, '0, '0));
    push(mkev(iltm_pkg::FUNC_RD_END, 8'd0, '1, '0, '0));
    push(mkev(iltm_pkg::FUNC_RD_END, 8'd0, '1, '0, '0));
    push(mkev(iltm_pkg::FUNC_WR_END, 8'd1, 32'd0, '0, '0));
    push(mkev(3'd6, '0, '0, '0, '0));
    push(mkev(3'd7, '0, '0, '0, '0));
    push(mkev(iltm_pkg::FUNC_UPDATE, '0, '0, '0, '0));
    drain();

    // pressure: receiver holds off while the sender keeps offering random traffic
    recv_hold_req = 1;
    @(posedge clk);
    while (hold_left == 0) @(posedge clk);
    recv_hold_req = 0;
    random_phase(60, 6);
    drain();

    // zero frequency, long update interval
    write_reg(iltm_pkg::CFG_TPS, 32'd0);
    write_reg(iltm_pkg::CFG_MIN_INT, 32'd5);
    write_reg(iltm_pkg::CFG_HALVE, 32'h000F_FFFF);
    random_phase(80, 8);
    ticks(6);
    push(mkev(iltm_pkg::FUNC_UPDATE, '0, '0, rand64(), rand64()));
    drain();

    // sender pause until all results are in, then largest tps with smallest interval and halving limit
    sender_pause = 1;
    drain();
    sender_pause = 0;
    write_reg(iltm_pkg::CFG_TPS, 32'hFFFF_FFFF);
    write_reg(iltm_pkg::CFG_MIN_INT, 32'd1);
    write_reg(iltm_pkg::CFG_HALVE, 32'd1);
    random_phase(120, 6);
    drain();

    write_reg(iltm_pkg::CFG_TPS, 32'd1);
    write_reg(iltm_pkg::CFG_MIN_INT, 32'hFFFF_FFFF);
    random_phase(40, 8);
    drain();
    write_reg(iltm_pkg::CFG_MIN_INT, 32'd2);
    write_reg(iltm_pkg::CFG_TPS, $urandom());
    random_phase(100, 8);
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
hw/rtl/iltm_pkg.sv
hw/rtl/iltm_event_if.sv
hw/rtl/iltm_result_if.sv
hw/rtl/iltm_cfg_if.sv
hw/rtl/iltm_ram.sv
hw/rtl/iltm_front.sv
hw/rtl/iltm_queue.sv
hw/rtl/iltm_muldiv.sv
hw/rtl/iltm_back.sv
hw/rtl/io_latency_throughput_monitor.sv
sim/iltm_tb_ifs.sv
sim/io_latency_throughput_monitor_tb.sv
